>>> sv/psv_pkg.sv
// Types and constants shared by the path string validator modules.
`timescale 1ns / 1ps

package psv_pkg;

    localparam int CH_W       = 8;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    localparam logic [COUNT_W-1:0] LENGTH_LIMIT_RST = 16'd4096;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS_RULES = 1'd1;

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CH_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CH_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CH_W-1:0] CH_PIPE   = 8'h7C;
    localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CH_W-1:0] CH_QMARK  = 8'h3F;
    localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CH_W-1:0] CH_DIG1   = 8'h31;
    localparam logic [CH_W-1:0] CH_DIG9   = 8'h39;

    localparam logic [23:0] NAME_CON = 24'h4E4F43;  // "CON", first byte low
    localparam logic [23:0] NAME_PRN = 24'h4E5250;
    localparam logic [23:0] NAME_AUX = 24'h585541;
    localparam logic [23:0] NAME_NUL = 24'h4C554E;
    localparam logic [23:0] NAME_COM = 24'h4D4F43;
    localparam logic [23:0] NAME_LPT = 24'h54504C;

    typedef enum logic [2:0] {
        REASON_OK,
        REASON_EMPTY,
        REASON_TOO_LONG,
        REASON_BAD_BYTE,
        REASON_DOT_SEGMENT,
        REASON_NOT_ABSOLUTE,
        REASON_RESERVED
    } reason_t;

    typedef struct packed {
        logic [COUNT_W-1:0] length_limit;
        logic               windows_rules;
    } cfg_t;

    typedef struct packed {
        reason_t reason;
        logic    path_ok;
    } verdict_t;

endpackage

>>> sv/psv_path_state.sv
// Per-path byte tracking and verdict logic for the path string validator.
`timescale 1ns / 1ps

module psv_path_state (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic [psv_pkg::CH_W-1:0]   ch,
    input  logic                       require_absolute,
    input  psv_pkg::cfg_t              cfg,
    output logic                       terminator,
    output psv_pkg::verdict_t          verdict
);

    logic [psv_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        bad_reg, bad_next;
    logic                        dotseg_reg, dotseg_next;
    logic [1:0]                  seg_len_reg, seg_len_next;
    logic                        all_dots_reg, all_dots_next;
    logic [15:0]                 prefix_reg, prefix_next;
    logic                        abs_match_reg, abs_match_next;
    logic [31:0]                 base_chars_reg, base_chars_next;
    logic [2:0]                  base_len_reg, base_len_next;
    logic                        base_dot_reg, base_dot_next;

    logic                        is_sep;
    logic                        is_bad;
    logic [psv_pkg::CH_W-1:0]    upper;
    logic                        first_alpha;
    logic                        dot_final;
    logic                        is_abs;
    logic                        reserved;
    logic                        digit_ok;
    psv_pkg::reason_t            reason;

    assign terminator = (ch == psv_pkg::CH_NUL);
    assign is_sep = (ch == psv_pkg::CH_SLASH) || (ch == psv_pkg::CH_BSLASH);
    assign is_bad = (ch < psv_pkg::CH_SPACE) ||
                    (cfg.windows_rules &&
                     ((ch == psv_pkg::CH_LT) || (ch == psv_pkg::CH_GT) ||
                      (ch == psv_pkg::CH_PIPE) || (ch == psv_pkg::CH_STAR) ||
                      (ch == psv_pkg::CH_QMARK) || (ch == psv_pkg::CH_QUOTE)));
    assign upper = (ch >= 8'h61 && ch <= 8'h7A) ? (ch - 8'h20) : ch;
    assign first_alpha = (prefix_reg[7:0] >= 8'h41 && prefix_reg[7:0] <= 8'h5A) ||
                         (prefix_reg[7:0] >= 8'h61 && prefix_reg[7:0] <= 8'h7A);

    always_comb begin
        count_next      = count_reg;
        bad_next        = bad_reg;
        dotseg_next     = dotseg_reg;
        seg_len_next    = seg_len_reg;
        all_dots_next   = all_dots_reg;
        prefix_next     = prefix_reg;
        abs_match_next  = abs_match_reg;
        base_chars_next = base_chars_reg;
        base_len_next   = base_len_reg;
        base_dot_next   = base_dot_reg;
        if (accept) begin
            if (terminator) begin
                count_next      = '0;
                bad_next        = 1'b0;
                dotseg_next     = 1'b0;
                seg_len_next    = '0;
                all_dots_next   = 1'b1;
                prefix_next     = '0;
                abs_match_next  = 1'b0;
                base_chars_next = '0;
                base_len_next   = '0;
                base_dot_next   = 1'b0;
            end else begin
                if (is_bad) begin
                    bad_next = 1'b1;
                end
                if (count_reg == 16'd0) begin
                    prefix_next = {8'h00, ch};
                end else if (count_reg == 16'd1) begin
                    prefix_next = {ch, prefix_reg[7:0]};
                end else if (count_reg == 16'd2) begin
                    abs_match_next = first_alpha && (prefix_reg[15:8] == psv_pkg::CH_COLON)
                                     && is_sep;
                end
                if (is_sep) begin
                    if ((seg_len_reg == 2'd1 || seg_len_reg == 2'd2) && all_dots_reg) begin
                        dotseg_next = 1'b1;
                    end
                    seg_len_next    = '0;
                    all_dots_next   = 1'b1;
                    base_chars_next = '0;
                    base_len_next   = '0;
                    base_dot_next   = 1'b0;
                end else begin
                    if (ch != psv_pkg::CH_DOT) begin
                        all_dots_next = 1'b0;
                    end
                    if (seg_len_reg != 2'd3) begin
                        seg_len_next = seg_len_reg + 2'd1;
                    end
                    if (!base_dot_reg) begin
                        if (ch == psv_pkg::CH_DOT) begin
                            base_dot_next = 1'b1;
                        end else begin
                            if (base_len_reg < 3'd4) begin
                                base_chars_next[{base_len_reg[1:0], 3'b000} +: 8] = upper;
                            end
                            if (base_len_reg < 3'd5) begin
                                base_len_next = base_len_reg + 3'd1;
                            end
                        end
                    end
                end
                if (count_reg != psv_pkg::COUNT_MAX) begin
                    count_next = count_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            bad_reg        <= 1'b0;
            dotseg_reg     <= 1'b0;
            seg_len_reg    <= '0;
            all_dots_reg   <= 1'b1;
            prefix_reg     <= '0;
            abs_match_reg  <= 1'b0;
            base_chars_reg <= '0;
            base_len_reg   <= '0;
            base_dot_reg   <= 1'b0;
        end else begin
            count_reg      <= count_next;
            bad_reg        <= bad_next;
            dotseg_reg     <= dotseg_next;
            seg_len_reg    <= seg_len_next;
            all_dots_reg   <= all_dots_next;
            prefix_reg     <= prefix_next;
            abs_match_reg  <= abs_match_next;
            base_chars_reg <= base_chars_next;
            base_len_reg   <= base_len_next;
            base_dot_reg   <= base_dot_next;
        end
    end

    // verdict for a terminator arriving now; the open segment closes with it
    always_comb begin
        dot_final = dotseg_reg ||
                    ((seg_len_reg == 2'd1 || seg_len_reg == 2'd2) && all_dots_reg);
        if (cfg.windows_rules) begin
            is_abs = abs_match_reg ||
                     ((count_reg >= 16'd2) &&
                      (prefix_reg == {psv_pkg::CH_BSLASH, psv_pkg::CH_BSLASH}));
        end else begin
            is_abs = (count_reg >= 16'd1) && (prefix_reg[7:0] == psv_pkg::CH_SLASH);
        end
        digit_ok = (base_chars_reg[31:24] >= psv_pkg::CH_DIG1) &&
                   (base_chars_reg[31:24] <= psv_pkg::CH_DIG9);
        reserved = 1'b0;
        if (base_len_reg == 3'd3) begin
            reserved = (base_chars_reg[23:0] == psv_pkg::NAME_CON) ||
                       (base_chars_reg[23:0] == psv_pkg::NAME_PRN) ||
                       (base_chars_reg[23:0] == psv_pkg::NAME_AUX) ||
                       (base_chars_reg[23:0] == psv_pkg::NAME_NUL);
        end else if (base_len_reg == 3'd4) begin
            reserved = digit_ok &&
                       ((base_chars_reg[23:0] == psv_pkg::NAME_COM) ||
                        (base_chars_reg[23:0] == psv_pkg::NAME_LPT));
        end

        if (count_reg == 16'd0) begin
            reason = psv_pkg::REASON_EMPTY;
        end else if (count_reg >= cfg.length_limit) begin
            reason = psv_pkg::REASON_TOO_LONG;
        end else if (bad_reg) begin
            reason = psv_pkg::REASON_BAD_BYTE;
        end else if (dot_final) begin
            reason = psv_pkg::REASON_DOT_SEGMENT;
        end else if (require_absolute && !is_abs) begin
            reason = psv_pkg::REASON_NOT_ABSOLUTE;
        end else if (cfg.windows_rules && reserved) begin
            reason = psv_pkg::REASON_RESERVED;
        end else begin
            reason = psv_pkg::REASON_OK;
        end
        verdict.reason  = reason;
        verdict.path_ok = (reason == psv_pkg::REASON_OK);
    end

endmodule

>>> sv/psv_out_buf.sv
// Two-entry output register with skid slot for the verdict stream.
`timescale 1ns / 1ps

module psv_out_buf (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  psv_pkg::verdict_t               verdict,
    output logic                            in_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [psv_pkg::M_TDATA_W-1:0]   m_tdata   // path_ok, reason[2:0], zero pad
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    psv_pkg::verdict_t main_reg, main_next;
    psv_pkg::verdict_t skid_reg, skid_next;
    logic              pop;

    assign pop      = main_valid_reg && m_tready;
    assign in_ready = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {{(psv_pkg::M_TDATA_W - 4){1'b0}}, main_reg.reason, main_reg.path_ok};

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = verdict;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = verdict;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

>>> sv/path_string_validator_top.sv
// Top level of the path string validator.
`timescale 1ns / 1ps
// Usage:
//   s_ channel: one path byte per word; a zero byte ends the path and also
//   carries the require_absolute flag. Nonzero bytes produce no output.
//   m_ channel: one verdict word per path: path_ok and a reason code
//   (0 ok, 1 empty, 2 too long, 3 bad byte, 4 dot segment, 5 not absolute,
//   6 reserved name), first failing check reported.
//   cfg channel: index 0 writes length_limit, index 1 writes windows_rules
//   (bit 0). Always ready; write only while no path is in flight.
// Output path: the verdict is registered in the output register, or in the skid
//   slot while the output register is held, once the terminator is accepted.
// Throughput: one byte per cycle while s_tready is high; the per-path flags and
//   counters update through combinational logic between the input handshake and the state.
// Reset: aresetn low clears the path state, empties the output, and returns
//   length_limit to 4096 and windows_rules to 0.
// Stall: a verdict waits in the output register while a second one can land
//   in the skid slot; s_tready drops only while the skid slot is occupied.

module path_string_validator_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [psv_pkg::S_TDATA_W-1:0]     s_tdata,   // ch[7:0], require_absolute, zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [psv_pkg::M_TDATA_W-1:0]     m_tdata,   // path_ok, reason[2:0], zero pad
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psv_pkg::CFG_DATA_W-1:0]    cfg_data
);

    psv_pkg::cfg_t     cfg_reg;
    psv_pkg::verdict_t verdict;
    logic              accept;
    logic              terminator;
    logic              buf_ready;

    assign cfg_ready = 1'b1;
    assign s_tready  = buf_ready;
    assign accept    = s_tvalid && buf_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.length_limit  <= psv_pkg::LENGTH_LIMIT_RST;
            cfg_reg.windows_rules <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                psv_pkg::CFG_LENGTH_LIMIT:  cfg_reg.length_limit  <= cfg_data;
                psv_pkg::CFG_WINDOWS_RULES: cfg_reg.windows_rules <= cfg_data[0];
                default: ;
            endcase
        end
    end

    psv_path_state u_state (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .ch               (s_tdata[psv_pkg::CH_W-1:0]),
        .require_absolute (s_tdata[psv_pkg::CH_W]),
        .cfg              (cfg_reg),
        .terminator       (terminator),
        .verdict          (verdict)
    );

    psv_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept && terminator),
        .verdict  (verdict),
        .in_ready (buf_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> sv/psv_checker.sv
// Port-level assertions for the path string validator, bound to the top level.
`timescale 1ns / 1ps

module psv_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [psv_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [psv_pkg::M_TDATA_W-1:0]   m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_ok_matches_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == 3'd0)) && (m_tdata[3:1] != 3'd7))
        else $error("path_ok disagrees with reason");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[7:0] != 8'd0) && !m_tvalid |=> !m_tvalid)
        else $error("verdict without a terminator");

endmodule

bind path_string_validator_top psv_checker u_psv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
